>>> rtl/sprite_mask_section_parser_assert.svh
// Assertion macros shared by the sprite-mask section parser RTL.
`ifndef SPRITE_MASK_SECTION_PARSER_ASSERT_SVH
`define SPRITE_MASK_SECTION_PARSER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define SMS_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sprite mask parser: implication violated");
// Next-cycle implication, disabled while reset is asserted.
`define SMS_ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sprite mask parser: next-cycle implication violated");
`else
`define SMS_ASSERT_IMP(name, clk, rst_n, pre, post)
`define SMS_ASSERT_NXT(name, clk, rst_n, pre, post)
`endif

`endif

>>> rtl/sms_pkg.sv
// Shared constants, codes and types of the sprite-mask section parser.
package sms_pkg;

    localparam int MAX_GROUPS = 256;
    localparam int MAX_MASKS  = 256;
    localparam int MAX_DECL   = 256;

    localparam int GRP_AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CG_W   = $clog2(MAX_GROUPS + 1);
    localparam int EM_W   = $clog2(MAX_MASKS + 1);

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_NULL  = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_MANY  = 3'd3;
    localparam logic [2:0] ST_TRUNC = 3'd4;
    localparam logic [2:0] ST_MID   = 3'd5;

    localparam logic KIND_MASK = 1'b0;
    localparam logic KIND_SUM  = 1'b1;

    typedef struct packed {
        logic [15:0] size;
        logic [15:0] ax;
        logic [15:0] ay;
    } t_group;

    typedef struct packed {
        logic               kind;
        logic [7:0]         src_x;
        logic [7:0]         src_y;
        logic signed [15:0] dst_x;
        logic signed [15:0] dst_y;
        logic [15:0]        depth;
        logic [15:0]        width;
        logic [15:0]        height;
        logic [8:0]         mask_total;
        logic [7:0]         draw_total;
        logic [2:0]         status;
    } t_result;

endpackage

>>> rtl/sms_in_if.sv
// Byte-stream input channel of the sprite-mask section parser.
interface sms_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output first_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                    output ready);
endinterface

>>> rtl/sms_out_if.sv
// Result channel of the sprite-mask section parser.
interface sms_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [7:0]         src_x;
    logic [7:0]         src_y;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic [15:0]        depth;
    logic [15:0]        width;
    logic [15:0]        height;
    logic [8:0]         mask_total;
    logic [7:0]         draw_total;
    logic [2:0]         status;

    modport source (output valid, output kind, output src_x, output src_y, output dst_x,
                    output dst_y, output depth, output width, output height,
                    output mask_total, output draw_total, output status, input ready);
    modport sink   (input valid, input kind, input src_x, input src_y, input dst_x,
                    input dst_y, input depth, input width, input height,
                    input mask_total, input draw_total, input status, output ready);
endinterface

>>> rtl/sms_group_ram.sv
// Group table memory: one write port, one registered read port.
module sms_group_ram (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [sms_pkg::GRP_AW-1:0]   i_wr_addr,
    input  sms_pkg::t_group              i_wr_data,
    input  logic [sms_pkg::GRP_AW-1:0]   i_rd_addr,
    output sms_pkg::t_group              o_rd_data
);

    sms_pkg::t_group r_mem [sms_pkg::MAX_GROUPS];
    sms_pkg::t_group r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/sms_mask_fmt.sv
// Builds a mask result from the captured record bytes and the group anchors.
module sms_mask_fmt (
    input  logic [63:0]       i_head,
    input  logic [31:0]       i_dims,
    input  logic [15:0]       i_ax,
    input  logic [15:0]       i_ay,
    output sms_pkg::t_result  o_mask
);

    logic        square;
    logic [15:0] side;

    // A nonzero size nibble means a square mask of nibble * 8 pixels.
    assign square = (i_head[63:60] != 4'd0);
    assign side   = 16'({i_head[63:60], 3'b000});

    always_comb begin
        o_mask            = '0;
        o_mask.kind       = sms_pkg::KIND_MASK;
        o_mask.src_x      = i_head[7:0];
        o_mask.src_y      = i_head[15:8];
        o_mask.dst_x      = 16'(16'(i_head[23:16]) + i_ax);
        o_mask.dst_y      = 16'(16'(i_head[31:24]) + i_ay);
        o_mask.depth      = i_head[47:32];
        o_mask.width      = square ? side : i_dims[15:0];
        o_mask.height     = square ? side : i_dims[31:16];
    end

endmodule

>>> rtl/sprite_mask_section_parser.sv
// Sprite-mask section parser top level: byte sequencer, group table and output register.
// A byte completing a mask record moves to a check state that skips each exhausted or
// empty group in turn and then emits the mask; a summary state follows when a summary
// is due. Results leave through a single output register.
// Reset is synchronous, active low, and clears all control state; the group table has no
// reset and needs no clearing pass, since every entry is written before it is read.
`include "sprite_mask_section_parser_assert.svh"
module sprite_mask_section_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sms_in_if.sink        i_in,
    sms_out_if.source     o_out
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_GROUPS = 3'd2;
    localparam logic [2:0] PH_MASKS  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [1:0] S_RUN = 2'd0;
    localparam logic [1:0] S_CHK = 2'd1;
    localparam logic [1:0] S_SUM = 2'd2;

    localparam int CG_W = sms_pkg::CG_W;
    localparam int EM_W = sms_pkg::EM_W;

    logic [1:0]       r_state, n_state;
    logic [2:0]       r_phase, n_phase;
    logic [3:0]       r_pos, n_pos;
    logic [15:0]      r_gd, n_gd;
    logic [15:0]      r_md, n_md;
    logic [CG_W-1:0]  r_cg, n_cg;
    logic [15:0]      r_used, n_used;
    logic [23:0]      r_mtb, n_mtb;
    logic [EM_W-1:0]  r_emitted, n_emitted;
    logic             r_last, n_last;
    logic [2:0]       r_sum_st, n_sum_st;
    logic [15:0]      r_gsz, n_gsz;
    logic [15:0]      r_gax, n_gax;
    logic [15:0]      r_gay, n_gay;
    logic [63:0]      r_head, n_head;
    logic [31:0]      r_dims, n_dims;
    logic             r_ov, n_ov;
    sms_pkg::t_result r_out, n_res;

    logic             in_acc;
    logic             out_free;
    logic             load_out;
    logic             wr_en;
    sms_pkg::t_group  wr_data;
    sms_pkg::t_group  rd_data;
    logic             in_grp;
    logic [15:0]      fmt_ax, fmt_ay;
    sms_pkg::t_result mask_res;
    logic [8:0]       sum_total;
    logic [7:0]       sum_draw;

    function automatic sms_pkg::t_result make_summary(input logic [2:0] st,
                                                      input logic [8:0] tot,
                                                      input logic [7:0] drw);
        sms_pkg::t_result res;
        res            = '0;
        res.kind       = sms_pkg::KIND_SUM;
        res.status     = st;
        if (st == sms_pkg::ST_OK || st == sms_pkg::ST_MID) begin
            res.mask_total = tot;
            res.draw_total = drw;
        end
        return res;
    endfunction

    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_RUN) && out_free;

    assign in_grp = (16'(r_cg) < r_gd);
    assign fmt_ax = in_grp ? rd_data.ax : 16'd0;
    assign fmt_ay = in_grp ? rd_data.ay : 16'd0;

    assign sum_total = 9'(r_emitted);
    assign sum_draw  = (16'(r_md[7:0]) < 16'(r_emitted)) ? r_md[7:0] : 8'(r_emitted);

    // The read port runs every cycle, but its data is used only in the mask phase, after the
    // last group write, so every entry that is used has been written for this section.
    sms_group_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cg[sms_pkg::GRP_AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (n_cg[sms_pkg::GRP_AW-1:0]),
        .o_rd_data (rd_data)
    );

    sms_mask_fmt u_fmt (
        .i_head (r_head),
        .i_dims (r_dims),
        .i_ax   (fmt_ax),
        .i_ay   (fmt_ay),
        .o_mask (mask_res)
    );

    always_comb begin
        logic [2:0]      ph;
        logic [3:0]      pos;
        logic [15:0]     gd;
        logic [15:0]     md;
        logic            done_rec;
        logic [23:0]     mtb_sum;
        logic [23:0]     mtb_dec;
        logic [CG_W-1:0] cg_inc;
        logic            emit;

        n_state   = r_state;
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_gd      = r_gd;
        n_md      = r_md;
        n_cg      = r_cg;
        n_used    = r_used;
        n_mtb     = r_mtb;
        n_emitted = r_emitted;
        n_last    = r_last;
        n_sum_st  = r_sum_st;
        n_gsz     = r_gsz;
        n_gax     = r_gax;
        n_gay     = r_gay;
        n_head    = r_head;
        n_dims    = r_dims;
        load_out  = 1'b0;
        n_res     = mask_res;
        wr_en     = 1'b0;
        wr_data   = '{size: r_gsz, ax: r_gax, ay: {i_in.data_byte, r_gay[7:0]}};

        ph       = r_phase;
        pos      = r_pos;
        gd       = r_gd;
        md       = r_md;
        done_rec = 1'b0;
        mtb_sum  = r_mtb + 24'(r_gsz);
        mtb_dec  = (r_mtb != 24'd0) ? r_mtb - 24'd1 : r_mtb;
        cg_inc   = r_cg + CG_W'(1);
        emit     = (r_emitted < EM_W'(sms_pkg::MAX_MASKS));

        unique case (r_state)
            S_RUN: begin
                if (in_acc) begin
                    if (i_in.first_byte) begin
                        ph        = PH_HEADER;
                        pos       = 4'd0;
                        gd        = 16'd0;
                        md        = 16'd0;
                        n_cg      = '0;
                        n_used    = 16'd0;
                        n_mtb     = 24'd0;
                        n_emitted = '0;
                    end
                    unique case (ph)
                        PH_HEADER: begin
                            case (pos[1:0])
                                2'd0: gd[7:0]  = i_in.data_byte;
                                2'd1: gd[15:8] = i_in.data_byte;
                                2'd2: md[7:0]  = i_in.data_byte;
                                default: md[15:8] = i_in.data_byte;
                            endcase
                            n_gd  = gd;
                            n_md  = md;
                            n_pos = {2'b00, pos[1:0]} + 4'd1;
                            if (pos[1:0] == 2'd3) begin
                                n_pos = 4'd0;
                                if (gd == 16'hFFFF && md == 16'hFFFF) begin
                                    load_out = 1'b1;
                                    n_res    = make_summary(sms_pkg::ST_NULL, 9'd0, 8'd0);
                                    ph       = PH_DONE;
                                end else if (gd == 16'd0 || md == 16'd0) begin
                                    load_out = 1'b1;
                                    n_res    = make_summary(sms_pkg::ST_EMPTY, 9'd0, 8'd0);
                                    ph       = PH_DONE;
                                end else if (gd > 16'(sms_pkg::MAX_GROUPS) ||
                                             md > 16'(sms_pkg::MAX_DECL)) begin
                                    load_out = 1'b1;
                                    n_res    = make_summary(sms_pkg::ST_MANY, 9'd0, 8'd0);
                                    ph       = PH_DONE;
                                end else begin
                                    ph   = PH_GROUPS;
                                    n_cg = '0;
                                end
                            end
                        end
                        PH_GROUPS: begin
                            case (pos[2:0])
                                3'd0: n_gsz[7:0]  = i_in.data_byte;
                                3'd1: n_gsz[15:8] = i_in.data_byte;
                                3'd4: n_gax[7:0]  = i_in.data_byte;
                                3'd5: n_gax[15:8] = i_in.data_byte;
                                3'd6: n_gay[7:0]  = i_in.data_byte;
                                3'd7: n_gay[15:8] = i_in.data_byte;
                                default: ;
                            endcase
                            n_pos = {1'b0, pos[2:0]} + 4'd1;
                            if (pos[2:0] == 3'd7) begin
                                n_pos = 4'd0;
                                wr_en = 1'b1;
                                n_mtb = mtb_sum;
                                n_cg  = cg_inc;
                                if (16'(cg_inc) >= r_gd) begin
                                    ph     = PH_MASKS;
                                    n_cg   = '0;
                                    n_used = 16'd0;
                                    if (mtb_sum == 24'd0) begin
                                        load_out = 1'b1;
                                        n_res    = make_summary(sms_pkg::ST_OK, 9'd0, 8'd0);
                                        ph       = PH_DONE;
                                    end
                                end
                            end
                        end
                        PH_MASKS: begin
                            n_pos = pos + 4'd1;
                            if (pos < 4'd8) begin
                                n_head[{pos[2:0], 3'b000} +: 8] = i_in.data_byte;
                                done_rec = (pos == 4'd7) && (i_in.data_byte[7:4] != 4'd0);
                            end else begin
                                n_dims[{pos[1:0], 3'b000} +: 8] = i_in.data_byte;
                                done_rec = (pos >= 4'd11);
                            end
                            if (done_rec) begin
                                n_pos   = 4'd0;
                                n_last  = i_in.last_byte;
                                n_state = S_CHK;
                            end
                        end
                        default: ;
                    endcase
                    // Running out of data while still parsing ends the run; a finished
                    // record handles the end of data after its mask is out.
                    if (i_in.last_byte && !done_rec &&
                        (ph == PH_HEADER || ph == PH_GROUPS || ph == PH_MASKS)) begin
                        load_out = 1'b1;
                        if (ph == PH_MASKS) begin
                            n_res = make_summary(sms_pkg::ST_MID, sum_total, sum_draw);
                        end else begin
                            n_res = make_summary(sms_pkg::ST_TRUNC, 9'd0, 8'd0);
                        end
                        ph = PH_DONE;
                    end
                    n_phase = ph;
                end
            end
            S_CHK: begin
                // Each skip moves to the next entry; its read data shows up next cycle.
                if (in_grp && r_used >= rd_data.size) begin
                    n_cg   = cg_inc;
                    n_used = 16'd0;
                end else if (!emit || out_free) begin
                    if (emit) begin
                        load_out  = 1'b1;
                        n_res     = mask_res;
                        n_emitted = r_emitted + EM_W'(1);
                    end
                    n_used = r_used + 16'd1;
                    n_mtb  = mtb_dec;
                    if (mtb_dec == 24'd0) begin
                        n_state  = S_SUM;
                        n_sum_st = sms_pkg::ST_OK;
                        n_phase  = PH_DONE;
                    end else if (r_last) begin
                        n_state  = S_SUM;
                        n_sum_st = sms_pkg::ST_MID;
                        n_phase  = PH_DONE;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_SUM: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_res    = make_summary(r_sum_st, sum_total, sum_draw);
                    n_state  = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase

        if (load_out) begin
            n_ov = 1'b1;
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RUN;
            r_phase   <= PH_IDLE;
            r_pos     <= 4'd0;
            r_gd      <= 16'd0;
            r_md      <= 16'd0;
            r_cg      <= '0;
            r_used    <= 16'd0;
            r_mtb     <= 24'd0;
            r_emitted <= '0;
            r_last    <= 1'b0;
            r_sum_st  <= sms_pkg::ST_OK;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_gd      <= n_gd;
            r_md      <= n_md;
            r_cg      <= n_cg;
            r_used    <= n_used;
            r_mtb     <= n_mtb;
            r_emitted <= n_emitted;
            r_last    <= n_last;
            r_sum_st  <= n_sum_st;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gsz  <= n_gsz;
        r_gax  <= n_gax;
        r_gay  <= n_gay;
        r_head <= n_head;
        r_dims <= n_dims;
        if (load_out) begin
            r_out <= n_res;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.kind       = r_out.kind;
    assign o_out.src_x      = r_out.src_x;
    assign o_out.src_y      = r_out.src_y;
    assign o_out.dst_x      = r_out.dst_x;
    assign o_out.dst_y      = r_out.dst_y;
    assign o_out.depth      = r_out.depth;
    assign o_out.width      = r_out.width;
    assign o_out.height     = r_out.height;
    assign o_out.mask_total = r_out.mask_total;
    assign o_out.draw_total = r_out.draw_total;
    assign o_out.status     = r_out.status;

    `SMS_ASSERT_IMP(a_no_write_outside_run, i_clk, i_rst_n, r_state != S_RUN, !wr_en)
    `SMS_ASSERT_IMP(a_load_only_when_free, i_clk, i_rst_n, load_out, out_free)
    `SMS_ASSERT_IMP(a_group_bound, i_clk, i_rst_n, r_phase == PH_MASKS, 16'(r_cg) <= r_gd)
    `SMS_ASSERT_IMP(a_mask_cap, i_clk, i_rst_n, load_out && n_res.kind == sms_pkg::KIND_MASK, r_emitted < EM_W'(sms_pkg::MAX_MASKS))
    `SMS_ASSERT_NXT(a_summary_follows, i_clk, i_rst_n, r_state == S_SUM && out_free, r_ov && r_out.kind == sms_pkg::KIND_SUM)

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the sprite-mask section parser: byte streams in, results checked.
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_ITEMS   = 1100;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 30;
    localparam int PRINT_LIMIT  = 100;
    localparam int TABLE_GROUPS = 40;

    typedef enum logic [2:0] {
        PS_IDLE,
        PS_HEADER,
        PS_GROUPS,
        PS_MASKS,
        PS_DONE
    } t_parse_state;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       typed;
        logic [2:0] status;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    sms_in_if  in_if ();
    sms_out_if out_if ();

    sprite_mask_section_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Directed bytes; a typed row carries the summary status that its byte must produce.
    t_stim_row directed_rows [28] = '{
        '{8'h05, 1'b1, 1'b1, 1'b1, sms_pkg::ST_TRUNC},
        '{8'hFF, 1'b1, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, 1'b1, sms_pkg::ST_NULL},
        '{8'h7A, 1'b0, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'h00, 1'b1, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'h00, 1'b0, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'h05, 1'b0, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'h00, 1'b0, 1'b0, 1'b1, sms_pkg::ST_EMPTY},
        '{8'h01, 1'b1, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'h01, 1'b0, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'h00, 1'b0, 1'b0, 1'b1, sms_pkg::ST_MANY},
        '{8'hFF, 1'b1, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b1, 1'b1, sms_pkg::ST_TRUNC},
        '{8'h01, 1'b1, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'h00, 1'b0, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'h01, 1'b0, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'h00, 1'b0, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'h00, 1'b0, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'h00, 1'b0, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'hAA, 1'b0, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'h55, 1'b0, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'h7F, 1'b0, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'h00, 1'b0, 1'b0, 1'b0, sms_pkg::ST_OK},
        '{8'h80, 1'b0, 1'b0, 1'b1, sms_pkg::ST_OK}
    };

    // Parser state as the testbench tracks it.
    t_parse_state ps = PS_IDLE;
    logic [3:0]   pos = '0;
    logic [15:0]  n_groups = '0;
    logic [15:0]  n_declared = '0;
    logic [15:0]  g_size [256];
    logic [15:0]  g_ax [256];
    logic [15:0]  g_ay [256];
    logic [8:0]   cur_grp = '0;
    logic [15:0]  used = '0;
    logic [23:0]  to_build = '0;
    logic [8:0]   emitted = '0;
    logic [63:0]  head = '0;
    logic [31:0]  dims = '0;

    sms_pkg::t_result step_results [$];
    sms_pkg::t_result pending_results [$];
    logic [7:0]       section_bytes [$];

    int   mismatches = 0;
    int   item_count = 0;
    int   cycle_count = 0;
    int   src_idle_pct = 0;
    int   snk_stall_pct = 0;
    logic hold_on;
    event hold_go;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Long receiver hold-off, counted here so the sender keeps offering bytes meanwhile.
    initial begin
        hold_on = 1'b0;
        forever begin
            @(hold_go);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_on <= 1'b0;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] wanted);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, seen,
                     wanted);
    endtask

    function automatic sms_pkg::t_result summary(input logic [2:0] st,
                                                 input logic [8:0] total,
                                                 input logic [7:0] drawn);
        sms_pkg::t_result r;
        r            = '0;
        r.kind       = sms_pkg::KIND_SUM;
        r.mask_total = total;
        r.draw_total = drawn;
        r.status     = st;
        return r;
    endfunction

    function automatic logic [7:0] draw_of();
        logic [8:0] d;
        d = {1'b0, n_declared[7:0]};
        return (d < emitted) ? d[7:0] : emitted[7:0];
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Advances the tracked parser by one byte and queues the results it causes.
    task automatic parse_byte(input logic [7:0] b, input logic fb, input logic lb);
        sms_pkg::t_result r;
        logic [7:0]       g;
        logic [7:0]       sz;
        logic             done_rec;
        logic [15:0]      w;
        logic [15:0]      h;
        logic [15:0]      ax;
        logic [15:0]      ay;
        if (fb) begin
            ps         = PS_HEADER;
            pos        = '0;
            n_groups   = '0;
            n_declared = '0;
            cur_grp    = '0;
            used       = '0;
            to_build   = '0;
            emitted    = '0;
            head       = '0;
            dims       = '0;
        end
        if (ps inside {PS_HEADER, PS_GROUPS, PS_MASKS}) begin
            case (ps)
                PS_HEADER: begin
                    if (pos < 2) n_groups[8*pos[0] +: 8] = b;
                    else n_declared[8*pos[0] +: 8] = b;
                    pos = pos + 1;
                    if (pos == 4) begin
                        pos = '0;
                        if (n_groups == 16'hFFFF && n_declared == 16'hFFFF) begin
                            step_results.push_back(summary(sms_pkg::ST_NULL, '0, '0));
                            ps = PS_DONE;
                        end else if (n_groups == 0 || n_declared == 0) begin
                            step_results.push_back(summary(sms_pkg::ST_EMPTY, '0, '0));
                            ps = PS_DONE;
                        end else if (n_groups > sms_pkg::MAX_GROUPS ||
                                     n_declared > sms_pkg::MAX_DECL) begin
                            step_results.push_back(summary(sms_pkg::ST_MANY, '0, '0));
                            ps = PS_DONE;
                        end else begin
                            ps      = PS_GROUPS;
                            cur_grp = '0;
                        end
                    end
                end
                PS_GROUPS: begin
                    g = cur_grp[7:0];
                    case (pos[2:0])
                        3'd0: g_size[g][7:0]  = b;
                        3'd1: g_size[g][15:8] = b;
                        3'd4: g_ax[g][7:0]    = b;
                        3'd5: g_ax[g][15:8]   = b;
                        3'd6: g_ay[g][7:0]    = b;
                        3'd7: g_ay[g][15:8]   = b;
                        default: ;
                    endcase
                    pos = pos + 1;
                    if (pos == 8) begin
                        pos      = '0;
                        to_build = to_build + {8'b0, g_size[g]};
                        cur_grp  = cur_grp + 1;
                        if (cur_grp >= n_groups) begin
                            ps      = PS_MASKS;
                            cur_grp = '0;
                            used    = '0;
                            if (to_build == 0) begin
                                step_results.push_back(summary(sms_pkg::ST_OK, '0, '0));
                                ps = PS_DONE;
                            end
                        end
                    end
                end
                default: begin
                    done_rec = 1'b0;
                    if (pos < 8) begin
                        head[8*pos[2:0] +: 8] = b;
                        pos = pos + 1;
                        if (pos == 8 && head[63:60] != 4'h0) done_rec = 1'b1;
                    end else begin
                        dims[8*pos[1:0] +: 8] = b;
                        pos = pos + 1;
                        if (pos >= 12) done_rec = 1'b1;
                    end
                    if (done_rec) begin
                        sz = head[63:56];
                        if (sz[7:4] == 4'h0) begin
                            w = dims[15:0];
                            h = dims[31:16];
                        end else begin
                            w = {9'b0, sz[7:4], 3'b0};
                            h = w;
                        end
                        // Exhausted and empty groups are passed over before the anchor lookup.
                        while (cur_grp < n_groups && used >= g_size[cur_grp[7:0]]) begin
                            cur_grp = cur_grp + 1;
                            used    = '0;
                        end
                        ax = '0;
                        ay = '0;
                        if (cur_grp < n_groups) begin
                            ax = g_ax[cur_grp[7:0]];
                            ay = g_ay[cur_grp[7:0]];
                        end
                        used = used + 1;
                        if (emitted < sms_pkg::MAX_MASKS) begin
                            r        = '0;
                            r.kind   = sms_pkg::KIND_MASK;
                            r.src_x  = head[7:0];
                            r.src_y  = head[15:8];
                            r.dst_x  = {8'b0, head[23:16]} + ax;
                            r.dst_y  = {8'b0, head[31:24]} + ay;
                            r.depth  = head[47:32];
                            r.width  = w;
                            r.height = h;
                            step_results.push_back(r);
                            emitted = emitted + 1;
                        end
                        if (to_build != 0) to_build = to_build - 1;
                        pos  = '0;
                        head = '0;
                        dims = '0;
                        if (to_build == 0) begin
                            step_results.push_back(summary(sms_pkg::ST_OK, emitted,
                                                           draw_of()));
                            ps = PS_DONE;
                        end
                    end
                end
            endcase
            if (lb && ps inside {PS_HEADER, PS_GROUPS, PS_MASKS}) begin
                if (ps == PS_MASKS)
                    step_results.push_back(summary(sms_pkg::ST_MID, emitted, draw_of()));
                else
                    step_results.push_back(summary(sms_pkg::ST_TRUNC, '0, '0));
                ps = PS_DONE;
            end
        end
    endtask

    // Offers one byte, waits for the transfer, then records what it should cause.
    task automatic send_byte(input logic [7:0] b, input logic fb, input logic lb,
                             input logic typed, input logic [2:0] st);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= b;
        in_if.first_byte <= fb;
        in_if.last_byte  <= lb;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        item_count++;
        parse_byte(b, fb, lb);
        if (typed) begin
            step_results.delete();
            pending_results.push_back(summary(st, '0, '0));
        end else begin
            while (step_results.size() != 0) pending_results.push_back(step_results.pop_front());
        end
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Lays out a well-formed section: header, group table, then the mask records.
    task automatic build_section(input int counts[$], input logic [15:0] declared);
        int          total;
        logic [15:0] v;
        logic [7:0]  b7;
        section_bytes.delete();
        total = 0;
        v = 16'(counts.size());
        section_bytes.push_back(v[7:0]);
        section_bytes.push_back(v[15:8]);
        section_bytes.push_back(declared[7:0]);
        section_bytes.push_back(declared[15:8]);
        foreach (counts[i]) begin
            v = 16'(counts[i]);
            section_bytes.push_back(v[7:0]);
            section_bytes.push_back(v[15:8]);
            section_bytes.push_back(8'($urandom));
            section_bytes.push_back(8'($urandom));
            v = pick_word();
            section_bytes.push_back(v[7:0]);
            section_bytes.push_back(v[15:8]);
            v = pick_word();
            section_bytes.push_back(v[7:0]);
            section_bytes.push_back(v[15:8]);
            total += counts[i];
        end
        repeat (total) begin
            repeat (7) section_bytes.push_back(pick_byte());
            b7 = 8'($urandom);
            if ($urandom_range(99) < 30) b7[7:4] = 4'h0;
            else if (b7[7:4] == 4'h0) b7[7:4] = 4'($urandom_range(1, 15));
            section_bytes.push_back(b7);
            if (b7[7:4] == 4'h0) repeat (4) section_bytes.push_back(pick_byte());
        end
    endtask

    task automatic send_section(input int last_at, input int stop_at);
        for (int i = 0; i < stop_at; i++)
            send_byte(section_bytes[i], i == 0, i == last_at, 1'b0, sms_pkg::ST_OK);
    endtask

    task automatic run_random_section();
        int          counts[$];
        int          pick;
        int          n;
        int          last_at;
        int          stop_at;
        logic [15:0] ng;
        logic [15:0] decl;
        pick = $urandom_range(99);
        if (pick < 72) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            repeat (n) counts.push_back(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 3));
            case ($urandom_range(5))
                0:       decl = 16'd256;
                1:       decl = 16'd1;
                2:       decl = 16'd255;
                default: decl = 16'($urandom_range(1, 256));
            endcase
            build_section(counts, decl);
            last_at = -1;
            stop_at = section_bytes.size();
            pick = $urandom_range(99);
            if (pick >= 93) begin
                // Cut short without an end mark; the next first byte restarts the parser.
                stop_at = $urandom_range(1, section_bytes.size() - 1);
            end else if (pick >= 80) begin
                last_at = $urandom_range(0, section_bytes.size() - 1);
                stop_at = last_at + 1;
            end else if (pick >= 55) begin
                last_at = section_bytes.size() - 1;
            end
            send_section(last_at, stop_at);
        end else if (pick < 84) begin
            case ($urandom_range(4))
                0: begin
                    ng   = 16'hFFFF;
                    decl = 16'hFFFF;
                end
                1: begin
                    ng   = 16'h0000;
                    decl = 16'($urandom);
                end
                2: begin
                    ng   = 16'($urandom_range(1, 256));
                    decl = 16'h0000;
                end
                3: begin
                    ng   = 16'($urandom_range(257, 65535));
                    decl = 16'($urandom);
                end
                default: begin
                    ng   = 16'($urandom_range(1, 256));
                    decl = 16'($urandom_range(257, 65535));
                end
            endcase
            section_bytes.delete();
            section_bytes.push_back(ng[7:0]);
            section_bytes.push_back(ng[15:8]);
            section_bytes.push_back(decl[7:0]);
            section_bytes.push_back(decl[15:8]);
            send_section(($urandom_range(9) == 0) ? 3 : -1, 4);
        end else begin
            n = $urandom_range(1, 12);
            repeat (n)
                send_byte(8'($urandom), $urandom_range(4) == 0, $urandom_range(9) == 0,
                          1'b0, sms_pkg::ST_OK);
        end
    endtask

    // Result side: random stalls, and each transfer checked against the oldest expectation.
    initial begin
        sms_pkg::t_result got;
        sms_pkg::t_result want;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.kind       = out_if.kind;
                got.src_x      = out_if.src_x;
                got.src_y      = out_if.src_y;
                got.dst_x      = out_if.dst_x;
                got.dst_y      = out_if.dst_y;
                got.depth      = out_if.depth;
                got.width      = out_if.width;
                got.height     = out_if.height;
                got.mask_total = out_if.mask_total;
                got.draw_total = out_if.draw_total;
                got.status     = out_if.status;
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending, status", got.status, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch("kind", got.kind, want.kind);
                    if (got.src_x !== want.src_x)
                        report_mismatch("src_x", got.src_x, want.src_x);
                    if (got.src_y !== want.src_y)
                        report_mismatch("src_y", got.src_y, want.src_y);
                    if (got.dst_x !== want.dst_x)
                        report_mismatch("dst_x", got.dst_x, want.dst_x);
                    if (got.dst_y !== want.dst_y)
                        report_mismatch("dst_y", got.dst_y, want.dst_y);
                    if (got.depth !== want.depth)
                        report_mismatch("depth", got.depth, want.depth);
                    if (got.width !== want.width)
                        report_mismatch("width", got.width, want.width);
                    if (got.height !== want.height)
                        report_mismatch("height", got.height, want.height);
                    if (got.mask_total !== want.mask_total)
                        report_mismatch("mask_total", got.mask_total, want.mask_total);
                    if (got.draw_total !== want.draw_total)
                        report_mismatch("draw_total", got.draw_total, want.draw_total);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                end
            end
            out_if.ready <= !hold_on && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial begin
        int counts[$];
        int start_items;
        foreach (g_size[i]) begin
            g_size[i] = '0;
            g_ax[i]   = '0;
            g_ay[i]   = '0;
        end
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.data_byte  = '0;
        in_if.first_byte = 1'b0;
        in_if.last_byte  = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].first, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].status);
        wait_drained();

        // The receiver holds off while a long section streams in, so the input backs up.
        counts.push_back(20);
        build_section(counts, 16'd20);
        -> hold_go;
        send_section(-1, section_bytes.size());
        wait_drained();

        // Long group table with runs of empty groups between the filled ones.
        counts.delete();
        for (int k = 0; k < TABLE_GROUPS; k++)
            counts.push_back((k == 0) ? 2 : (k == 17) ? 1 : (k == TABLE_GROUPS - 1) ? 3 : 0);
        build_section(counts, 16'd200);
        send_section(section_bytes.size() - 1, section_bytes.size());
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct  = 65;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 65;
                end
                default: begin
                    src_idle_pct  = 29;
                    snk_stall_pct = 29;
                end
            endcase
            start_items = item_count;
            while (item_count - start_items < RAND_ITEMS / 4) run_random_section();
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
